/* hdl/sdf_pkg.sv */
package sdf_pkg;

  localparam logic [15:0] LIFETIME_RESET  = 16'd30;
  localparam int          WINDOW_BITS     = 32;
  // Differences at or above this value (as unsigned) lie within the window.
  localparam logic [15:0] WINDOW_LOW_EDGE = 16'hFFE1;
  localparam logic [15:0] WINDOW_SPAN     = 16'd32;
  localparam logic [4:0]  LOW_COUNT_LIMIT = 5'd16;
  localparam logic [4:0]  LOW_COUNT_MAX   = 5'd31;

  localparam logic MODE_MESSAGE = 1'b0;
  localparam logic MODE_TICK    = 1'b1;

  localparam logic [2:0] STATUS_NEW       = 3'd0;
  localparam logic [2:0] STATUS_SEQ_RESET = 3'd1;
  localparam logic [2:0] STATUS_TOO_OLD   = 3'd2;
  localparam logic [2:0] STATUS_DUPLICATE = 3'd3;
  localparam logic [2:0] STATUS_OLD_NEW   = 3'd4;

  typedef struct packed {
    logic        mode;
    logic        forwarding;
    logic [63:0] originator_high;
    logic [63:0] originator_low;
    logic [15:0] seqno;
  } item_t;

  typedef struct packed {
    logic                   valid;
    logic                   forwarding;
    logic [63:0]            addr_high;
    logic [63:0]            addr_low;
    logic [15:0]            last_seqno;
    logic [WINDOW_BITS-1:0] seen_window;
    logic [4:0]             low_count;
    logic [15:0]            age;
  } entry_t;

  typedef struct packed {
    logic       is_duplicate;
    logic [2:0] status;
  } res_t;

endpackage

/* hdl/sdf_channels.sv */
interface sdf_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic        forwarding;
  logic [63:0] originator_high;
  logic [63:0] originator_low;
  logic [15:0] seqno;

  modport source (output valid, mode, forwarding, originator_high, originator_low, seqno,
                  input ready);
  modport sink (input valid, mode, forwarding, originator_high, originator_low, seqno,
                output ready);
endinterface

interface sdf_out_if;
  logic       valid;
  logic       ready;
  logic       is_duplicate;
  logic [2:0] status;

  modport source (output valid, is_duplicate, status, input ready);
  modport sink (input valid, is_duplicate, status, output ready);
endinterface

interface sdf_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] entry_lifetime;

  modport source (output valid, entry_lifetime, input ready);
  modport sink (input valid, entry_lifetime, output ready);
endinterface

/* hdl/seqno_duplicate_filter_top.sv */
// Sequence-number duplicate filter with one table entry per originator and forwarding flag.
// in_bus carries message beats (mode 0) and ageing tick beats (mode 1).
// out_bus carries one result beat per message beat and none per tick beat.
// cfg_bus writes entry_lifetime; it is always ready, and the user must write it
// only while the block is idle; the block itself does not enforce this.
// Every beat walks the whole table in one memory, reading one entry per cycle.
// One item is worked on at a time; a finished result waits in the output
// register while the next item is accepted and scanned.
// After reset the table is cleared one entry per cycle, during which in_bus
// is not ready; cfg_bus writes are still taken.
// When the receiver stalls, the result holds on out_bus and a following
// message waits at the end of its scan until the output register is free.
module seqno_duplicate_filter_top #(
  parameter int TABLE_ENTRIES = 64
) (
  input logic       clk,
  input logic       rst_n,
  sdf_in_if.sink    in_bus,
  sdf_out_if.source out_bus,
  sdf_cfg_if.sink   cfg_bus
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pend_r, pend_nxt;
  logic [IDX_W-1:0] pidx_r, pidx_nxt;
  logic             hit_found_r, hit_found_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic             free_found_r, free_found_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [15:0]      lifetime_r, lifetime_nxt;
  sdf_pkg::res_t    res_r, res_nxt;
  sdf_pkg::item_t   item_r, item_nxt;
  sdf_pkg::entry_t  hit_word_r, hit_word_nxt;

  sdf_pkg::entry_t  mem [TABLE_ENTRIES];
  sdf_pkg::entry_t  rd_data_r;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  sdf_pkg::entry_t  wr_data;

  sdf_pkg::entry_t  upd_entry;
  sdf_pkg::res_t    upd_res;
  sdf_pkg::entry_t  new_entry;
  logic             match;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  sdf_update u_update (
    .entry_i    (hit_word_r),
    .seqno_i    (item_r.seqno),
    .lifetime_i (lifetime_r),
    .entry_o    (upd_entry),
    .res_o      (upd_res)
  );

  assign match = (rd_data_r.forwarding == item_r.forwarding) &&
                 (rd_data_r.addr_high == item_r.originator_high) &&
                 (rd_data_r.addr_low == item_r.originator_low);

  always_comb begin
    new_entry             = '0;
    new_entry.valid       = 1'b1;
    new_entry.forwarding  = item_r.forwarding;
    new_entry.addr_high   = item_r.originator_high;
    new_entry.addr_low    = item_r.originator_low;
    new_entry.last_seqno  = item_r.seqno;
    new_entry.seen_window = {{(sdf_pkg::WINDOW_BITS-1){1'b0}}, 1'b1};
    new_entry.age         = lifetime_r;
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    pend_nxt       = 1'b0;
    pidx_nxt       = pidx_r;
    hit_found_nxt  = hit_found_r;
    hit_idx_nxt    = hit_idx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    hit_word_nxt   = hit_word_r;
    item_nxt       = item_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r && !out_bus.ready;
    lifetime_nxt   = cfg_bus.valid ? cfg_bus.entry_lifetime : lifetime_r;
    rd_en          = 1'b0;
    rd_addr        = cnt_r[IDX_W-1:0];
    wr_en          = 1'b0;
    wr_addr        = pidx_r;
    wr_data        = rd_data_r;

    unique case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = cnt_r[IDX_W-1:0];
        wr_data = '0;
        if (cnt_r == CNT_W'(TABLE_ENTRIES - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_IDLE: begin
        if (in_bus.valid) begin
          item_nxt.mode            = in_bus.mode;
          item_nxt.forwarding      = in_bus.forwarding;
          item_nxt.originator_high = in_bus.originator_high;
          item_nxt.originator_low  = in_bus.originator_low;
          item_nxt.seqno           = in_bus.seqno;
          cnt_nxt        = '0;
          hit_found_nxt  = 1'b0;
          free_found_nxt = 1'b0;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_r < CNT_W'(TABLE_ENTRIES)) begin
          rd_en    = 1'b1;
          pend_nxt = 1'b1;
          pidx_nxt = cnt_r[IDX_W-1:0];
          cnt_nxt  = cnt_r + CNT_W'(1);
        end
        if (pend_r) begin
          if (item_r.mode == sdf_pkg::MODE_TICK) begin
            if (rd_data_r.valid) begin
              wr_en = 1'b1;
              if (rd_data_r.age <= 16'd1) begin
                wr_data.valid = 1'b0;
              end else begin
                wr_data.age = rd_data_r.age - 16'd1;
              end
            end
          end else if (rd_data_r.valid) begin
            if (!hit_found_r && match) begin
              hit_found_nxt = 1'b1;
              hit_idx_nxt   = pidx_r;
              hit_word_nxt  = rd_data_r;
            end
          end else if (!free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = pidx_r;
          end
        end else if (cnt_r == CNT_W'(TABLE_ENTRIES)) begin
          state_nxt = (item_r.mode == sdf_pkg::MODE_TICK) ? ST_IDLE : ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!out_valid_r || out_bus.ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (hit_found_r) begin
            wr_en   = 1'b1;
            wr_addr = hit_idx_r;
            wr_data = upd_entry;
            res_nxt = upd_res;
          end else begin
            res_nxt.is_duplicate = 1'b0;
            res_nxt.status       = sdf_pkg::STATUS_NEW;
            if (free_found_r) begin
              wr_en   = 1'b1;
              wr_addr = free_idx_r;
              wr_data = new_entry;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      cnt_r        <= '0;
      pend_r       <= 1'b0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
      lifetime_r   <= sdf_pkg::LIFETIME_RESET;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      pend_r       <= pend_nxt;
      hit_found_r  <= hit_found_nxt;
      free_found_r <= free_found_nxt;
      out_valid_r  <= out_valid_nxt;
      lifetime_r   <= lifetime_nxt;
    end
    pidx_r     <= pidx_nxt;
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
    hit_word_r <= hit_word_nxt;
    item_r     <= item_nxt;
    res_r      <= res_nxt;
  end

  assign in_bus.ready         = (state_r == ST_IDLE);
  assign cfg_bus.ready        = 1'b1;
  assign out_bus.valid        = out_valid_r;
  assign out_bus.is_duplicate = res_r.is_duplicate;
  assign out_bus.status       = res_r.status;

endmodule

/* hdl/sdf_update.sv */
module sdf_update (
  input  sdf_pkg::entry_t entry_i,
  input  logic [15:0]     seqno_i,
  input  logic [15:0]     lifetime_i,
  output sdf_pkg::entry_t entry_o,
  output sdf_pkg::res_t   res_o
);

  logic [15:0] diff;
  logic [15:0] back;
  logic [4:0]  low_inc;
  logic [sdf_pkg::WINDOW_BITS-1:0] back_bit;

  assign diff     = seqno_i - entry_i.last_seqno;
  assign back     = 16'd0 - diff;
  assign back_bit = {{(sdf_pkg::WINDOW_BITS-1){1'b0}}, 1'b1} << back[4:0];
  assign low_inc  = (entry_i.low_count < sdf_pkg::LOW_COUNT_MAX) ?
                    entry_i.low_count + 5'd1 : entry_i.low_count;

  always_comb begin
    entry_o     = entry_i;
    entry_o.age = lifetime_i;
    res_o.is_duplicate = 1'b0;
    res_o.status       = sdf_pkg::STATUS_NEW;
    if (diff[15] && (diff < sdf_pkg::WINDOW_LOW_EDGE)) begin
      if (low_inc > sdf_pkg::LOW_COUNT_LIMIT) begin
        entry_o.low_count   = 5'd0;
        entry_o.last_seqno  = seqno_i;
        entry_o.seen_window = {{(sdf_pkg::WINDOW_BITS-1){1'b0}}, 1'b1};
        res_o.status        = sdf_pkg::STATUS_SEQ_RESET;
      end else begin
        entry_o.low_count  = low_inc;
        res_o.is_duplicate = 1'b1;
        res_o.status       = sdf_pkg::STATUS_TOO_OLD;
      end
    end else if ((diff == 16'd0) || diff[15]) begin
      entry_o.low_count = 5'd0;
      if ((entry_i.seen_window & back_bit) != '0) begin
        res_o.is_duplicate = 1'b1;
        res_o.status       = sdf_pkg::STATUS_DUPLICATE;
      end else begin
        entry_o.seen_window = entry_i.seen_window | back_bit;
        res_o.status        = sdf_pkg::STATUS_OLD_NEW;
      end
    end else begin
      entry_o.low_count = 5'd0;
      if (diff < sdf_pkg::WINDOW_SPAN) begin
        entry_o.seen_window = (entry_i.seen_window << diff[4:0]) |
                              {{(sdf_pkg::WINDOW_BITS-1){1'b0}}, 1'b1};
      end else begin
        entry_o.seen_window = {{(sdf_pkg::WINDOW_BITS-1){1'b0}}, 1'b1};
      end
      entry_o.last_seqno = seqno_i;
    end
  end

endmodule

/* hdl/sdf_checker.sv */
module sdf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_is_duplicate,
  input logic [2:0] out_status
);

  // A result beat waiting for the receiver is not withdrawn.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // An accepted beat keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted beat");

  // The drop flag agrees with the status code.
  a_dup_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_duplicate == ((out_status == sdf_pkg::STATUS_TOO_OLD) ||
                                        (out_status == sdf_pkg::STATUS_DUPLICATE))))
    else $error("drop flag does not match status");

  // Reset leaves no result beat behind.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat present after reset");

endmodule

bind seqno_duplicate_filter_top sdf_checker u_sdf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_bus.valid),
  .in_ready         (in_bus.ready),
  .out_valid        (out_bus.valid),
  .out_ready        (out_bus.ready),
  .out_is_duplicate (out_bus.is_duplicate),
  .out_status       (out_bus.status)
);

/* sim/tb_top.sv */
module tb_top;

  localparam int N_SLOTS = 64;
  localparam int POOL_SIZE = 12;

  logic clk = 1'b0;
  logic rst_n;

  sdf_in_if in_bus();
  sdf_out_if out_bus();
  sdf_cfg_if cfg_bus();

  seqno_duplicate_filter_top #(.TABLE_ENTRIES(N_SLOTS)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_bus(in_bus),
    .out_bus(out_bus),
    .cfg_bus(cfg_bus)
  );

  always #5 clk = ~clk;

  // Shadow copy of the originator table.
  logic        slot_used [N_SLOTS];
  logic        slot_fwd [N_SLOTS];
  logic [63:0] slot_hi [N_SLOTS];
  logic [63:0] slot_lo [N_SLOTS];
  logic [15:0] slot_last [N_SLOTS];
  logic [31:0] slot_window [N_SLOTS];
  logic [4:0]  slot_low [N_SLOTS];
  logic [15:0] slot_age [N_SLOTS];
  logic [15:0] lifetime_shadow = sdf_pkg::LIFETIME_RESET;

  sdf_pkg::item_t pending_items[$];
  sdf_pkg::res_t  expected_verdicts[$];
  int    items_in_flight = 0;
  int    mismatch_count = 0;
  logic  in_beat_taken = 1'b0;
  logic  cfg_beat_taken = 1'b0;

  logic        pool_fwd [POOL_SIZE];
  logic [63:0] pool_hi [POOL_SIZE];
  logic [63:0] pool_lo [POOL_SIZE];
  logic [15:0] pool_seq [POOL_SIZE];

  function automatic bit classify_seqno(input sdf_pkg::item_t it,
                                        output sdf_pkg::res_t verdict);
    int hit;
    int free_idx;
    logic [15:0] d;
    logic [15:0] back;
    logic [31:0] mask;
    hit = -1;
    free_idx = -1;
    verdict.is_duplicate = 1'b0;
    verdict.status = sdf_pkg::STATUS_NEW;
    if (it.mode == sdf_pkg::MODE_TICK) begin
      for (int i = 0; i < N_SLOTS; i++) begin
        if (slot_used[i]) begin
          if (slot_age[i] <= 16'd1) slot_used[i] = 1'b0;
          else slot_age[i] = slot_age[i] - 16'd1;
        end
      end
      return 1'b0;
    end
    for (int i = 0; i < N_SLOTS; i++) begin
      if (slot_used[i]) begin
        if (hit < 0 && slot_fwd[i] == it.forwarding && slot_hi[i] == it.originator_high &&
            slot_lo[i] == it.originator_low) hit = i;
      end else if (free_idx < 0) begin
        free_idx = i;
      end
    end
    if (hit >= 0) begin
      slot_age[hit] = lifetime_shadow;
      d = it.seqno - slot_last[hit];
      if (d[15] && d < sdf_pkg::WINDOW_LOW_EDGE) begin
        if (slot_low[hit] < sdf_pkg::LOW_COUNT_MAX) slot_low[hit] = slot_low[hit] + 5'd1;
        if (slot_low[hit] > sdf_pkg::LOW_COUNT_LIMIT) begin
          slot_low[hit] = '0;
          slot_last[hit] = it.seqno;
          slot_window[hit] = 32'd1;
          verdict.status = sdf_pkg::STATUS_SEQ_RESET;
        end else begin
          verdict.is_duplicate = 1'b1;
          verdict.status = sdf_pkg::STATUS_TOO_OLD;
        end
      end else if (d == 16'd0 || d[15]) begin
        slot_low[hit] = '0;
        back = -d;
        mask = 32'd1 << back[4:0];
        if ((slot_window[hit] & mask) != 0) begin
          verdict.is_duplicate = 1'b1;
          verdict.status = sdf_pkg::STATUS_DUPLICATE;
        end else begin
          slot_window[hit] = slot_window[hit] | mask;
          verdict.status = sdf_pkg::STATUS_OLD_NEW;
        end
      end else begin
        slot_low[hit] = '0;
        slot_window[hit] = (d < sdf_pkg::WINDOW_SPAN) ? (slot_window[hit] << d) : 32'd0;
        slot_window[hit] = slot_window[hit] | 32'd1;
        slot_last[hit] = it.seqno;
      end
    end else if (free_idx >= 0) begin
      slot_used[free_idx] = 1'b1;
      slot_fwd[free_idx] = it.forwarding;
      slot_hi[free_idx] = it.originator_high;
      slot_lo[free_idx] = it.originator_low;
      slot_last[free_idx] = it.seqno;
      slot_window[free_idx] = 32'd1;
      slot_low[free_idx] = '0;
      slot_age[free_idx] = lifetime_shadow;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic queue_message(input logic fwd, input logic [63:0] hi, input logic [63:0] lo,
                               input logic [15:0] seq);
    sdf_pkg::item_t it;
    it.mode = sdf_pkg::MODE_MESSAGE;
    it.forwarding = fwd;
    it.originator_high = hi;
    it.originator_low = lo;
    it.seqno = seq;
    items_in_flight++;
    pending_items.push_back(it);
  endtask

  task automatic queue_tick();
    sdf_pkg::item_t it;
    it.mode = sdf_pkg::MODE_TICK;
    it.forwarding = $urandom_range(0, 1);
    it.originator_high = {$urandom, $urandom};
    it.originator_low = {$urandom, $urandom};
    it.seqno = $urandom;
    items_in_flight++;
    pending_items.push_back(it);
  endtask

  // Waits until every beat is taken and every message answered, then lets a tick finish.
  task automatic wait_idle();
    while (items_in_flight != 0 || expected_verdicts.size() != 0) @(negedge clk);
    repeat (N_SLOTS + 8) @(negedge clk);
  endtask

  task automatic write_lifetime(input logic [15:0] value);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.entry_lifetime <= value;
    do @(negedge clk); while (!cfg_beat_taken);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic run_random(input int n_msgs, input int tick_pct, input int fresh_pct);
    int m;
    int p;
    int kind;
    int run_len;
    logic [15:0] s;
    m = 0;
    while (m < n_msgs) begin
      if ($urandom_range(0, 99) < tick_pct) begin
        queue_tick();
      end else if ($urandom_range(0, 99) < fresh_pct) begin
        queue_message($urandom_range(0, 1), {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
        m++;
      end else begin
        p = $urandom_range(0, POOL_SIZE - 1);
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
          pool_seq[p] = pool_seq[p] + $urandom_range(1, 40);
          queue_message(pool_fwd[p], pool_hi[p], pool_lo[p], pool_seq[p]);
        end else if (kind < 65) begin
          queue_message(pool_fwd[p], pool_hi[p], pool_lo[p], pool_seq[p] - $urandom_range(0, 31));
        end else if (kind < 75) begin
          pool_seq[p] = pool_seq[p] + $urandom_range(32, 16'h7FFF);
          queue_message(pool_fwd[p], pool_hi[p], pool_lo[p], pool_seq[p]);
        end else if (kind < 85) begin
          queue_message(pool_fwd[p], pool_hi[p], pool_lo[p],
                        pool_seq[p] - $urandom_range(32, 32768));
        end else if (kind < 90) begin
          // A run of stale numbers that may be long enough to force a sequence restart.
          run_len = $urandom_range(16, 18);
          s = pool_seq[p];
          for (int k = 0; k < run_len; k++) begin
            s = pool_seq[p] - $urandom_range(32, 32768);
            queue_message(pool_fwd[p], pool_hi[p], pool_lo[p], s);
          end
          pool_seq[p] = s;
          m += run_len - 1;
        end else begin
          queue_message(pool_fwd[p], pool_hi[p], pool_lo[p], $urandom);
        end
        m++;
      end
    end
  endtask

  initial begin
    in_bus.valid = 1'b0;
    in_bus.mode = sdf_pkg::MODE_MESSAGE;
    in_bus.forwarding = 1'b0;
    in_bus.originator_high = '0;
    in_bus.originator_low = '0;
    in_bus.seqno = '0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.entry_lifetime = '0;
    for (int i = 0; i < N_SLOTS; i++) slot_used[i] = 1'b0;
  end

  int burst_left = 8;
  int gap_left = 0;

  always @(negedge clk) begin
    sdf_pkg::item_t it;
    if (!in_bus.valid || in_beat_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_bus.valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        in_bus.mode <= it.mode;
        in_bus.forwarding <= it.forwarding;
        in_bus.originator_high <= it.originator_high;
        in_bus.originator_low <= it.originator_low;
        in_bus.seqno <= it.seqno;
        in_bus.valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 200) : $urandom_range(0, 4);
        end
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  int rx_cycle = 0;
  int rx_mode = 0;
  int rx_hold = 0;
  logic rx_phase = 1'b1;
  logic [31:0] rx_pattern = '1;

  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle % 300 == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_pattern = $urandom;
    end
    case (rx_mode)
      0: begin
        out_bus.ready <= 1'b1;
      end
      1: begin
        out_bus.ready <= ($urandom_range(0, 3) != 0);
      end
      2: begin
        out_bus.ready <= rx_pattern[rx_cycle % 32];
      end
      default: begin
        if (rx_hold <= 0) begin
          rx_phase = ~rx_phase;
          rx_hold = rx_phase ? $urandom_range(1, 30) : $urandom_range(20, 80);
        end
        rx_hold--;
        out_bus.ready <= rx_phase;
      end
    endcase
  end

  always @(posedge clk) begin
    sdf_pkg::item_t it;
    sdf_pkg::res_t got;
    sdf_pkg::res_t want;
    sdf_pkg::res_t verdict;
    in_beat_taken <= rst_n && in_bus.valid && in_bus.ready;
    cfg_beat_taken <= rst_n && cfg_bus.valid && cfg_bus.ready;
    if (rst_n) begin
      if (cfg_bus.valid && cfg_bus.ready) lifetime_shadow = cfg_bus.entry_lifetime;
      if (out_bus.valid && out_bus.ready) begin
        got.is_duplicate = out_bus.is_duplicate;
        got.status = out_bus.status;
        if (expected_verdicts.size() == 0) begin
          report_mismatch($sformatf("unexpected result beat dup=%0b status=%0d",
                                    got.is_duplicate, got.status));
        end else begin
          want = expected_verdicts.pop_front();
          if (got.is_duplicate !== want.is_duplicate)
            report_mismatch($sformatf("is_duplicate %0b, expected %0b",
                                      got.is_duplicate, want.is_duplicate));
          if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        it = {in_bus.mode, in_bus.forwarding, in_bus.originator_high, in_bus.originator_low,
              in_bus.seqno};
        items_in_flight--;
        if (classify_seqno(it, verdict)) expected_verdicts.push_back(verdict);
      end
    end
  end

  initial begin
    logic [63:0] last_hi;
    logic [63:0] last_lo;
    logic        last_fwd;
    logic [15:0] last_seq;
    logic [15:0] s;
    rst_n = 1'b0;
    for (int k = 0; k < POOL_SIZE; k++) begin
      pool_fwd[k] = $urandom_range(0, 1);
      pool_hi[k] = (k % 3 == 0) ? 64'd0 : {$urandom, $urandom};
      pool_lo[k] = (k % 3 == 0) ? {32'd0, $urandom} : {$urandom, $urandom};
      pool_seq[k] = $urandom;
    end
    pool_fwd[1] = ~pool_fwd[0];
    pool_hi[1] = pool_hi[0];
    pool_lo[1] = pool_lo[0];
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    queue_message(1'b1, '1, '1, 16'd0);
    queue_message(1'b1, '1, '1, 16'd0);
    queue_message(1'b1, '1, '1, 16'hFFFF);
    queue_message(1'b1, '1, '1, 16'hFFFF);
    queue_message(1'b1, '1, '1, 16'd31);
    queue_message(1'b1, '1, '1, 16'd0);
    queue_message(1'b1, '1, '1, 16'd63);
    queue_message(1'b1, '1, '1, 16'd31);
    queue_message(1'b0, '1, '1, 16'd31);
    queue_message(1'b0, '0, '0, 16'd100);
    queue_message(1'b0, '0, '0, 16'd100 + 16'h7FFF);
    queue_message(1'b0, '0, '0, 16'd99);
    s = 16'd100 + 16'h7FFF - 16'd32;
    for (int k = 0; k < 16; k++) queue_message(1'b0, '0, '0, s - k);
    queue_message(1'b0, '0, '0, s - 16'd15);
    queue_tick();
    wait_idle();

    write_lifetime(16'd1);
    queue_message(1'b0, 64'd0, 64'h0A00_0001, 16'd5);
    queue_tick();
    queue_message(1'b0, 64'd0, 64'h0A00_0001, 16'd5);
    wait_idle();

    write_lifetime(16'd0);
    queue_message(1'b1, 64'd0, 64'hC0A8_0001, 16'd7);
    queue_message(1'b1, 64'd0, 64'hC0A8_0001, 16'd7);
    queue_tick();
    queue_message(1'b1, 64'd0, 64'hC0A8_0001, 16'd7);
    wait_idle();

    write_lifetime(16'd3);
    for (int k = 0; k < 70; k++) begin
      last_fwd = $urandom_range(0, 1);
      last_hi = {$urandom, $urandom};
      last_lo = {$urandom, $urandom};
      last_seq = $urandom;
      queue_message(last_fwd, last_hi, last_lo, last_seq);
    end
    queue_message(last_fwd, last_hi, last_lo, last_seq);
    repeat (3) queue_tick();
    wait_idle();

    write_lifetime(sdf_pkg::LIFETIME_RESET);
    run_random(520, 5, 10);
    wait_idle();

    write_lifetime(16'hFFFF);
    run_random(340, 3, 2);
    wait_idle();

    write_lifetime(16'd4);
    run_random(600, 12, 8);
    wait_idle();

    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
